// ----- sv/uwf_pkg.sv -----
package uwf_pkg;

  localparam int MaxWordLen = 32;
  localparam int TableDepth = 256;
  localparam int LenW = $clog2(MaxWordLen + 1);
  localparam int PosW = $clog2(MaxWordLen);
  localparam int EntW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int SeenAw = EntW + PosW;

  localparam logic [7:0] NewlineByte = 8'd10;

  // Result item as it leaves the emitter.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       truncated;
    logic       table_full;
  } result_t;

  // C-locale white space or punctuation.
  function automatic logic is_separator(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) r = 1'b1;
    if (c >= 8'd33 && c <= 8'd47) r = 1'b1;
    if (c >= 8'd58 && c <= 8'd64) r = 1'b1;
    if (c >= 8'd91 && c <= 8'd96) r = 1'b1;
    if (c >= 8'd123 && c <= 8'd126) r = 1'b1;
    return r;
  endfunction

endpackage

// ----- sv/uwf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module uwf_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/unique_word_filter_core.sv -----
// Channel | Dir | tdata                         | tuser
// s_axis  | in  | [7:0] char_byte               | [0] kind
// m_axis  | out | [7:0] out_byte                | [0] truncated, [1] table_full; tlast=last
//
// A word byte is buffered. A word end walks the seen table: each stored entry of
// matching length is compared one byte a cycle through the seen-byte RAM read
// port (length check in StLen then StLenW per entry); after a setup step a new
// word is copied while the table has room and emitted one byte a cycle while the
// output is not stalled, its length plus one results in all. The table needs no
// clearing pass; a fill count bounds the search. Reset is synchronous; a stalled
// output holds the emitter and no input is taken until a word end completes.
module unique_word_filter_core
  import uwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tuser,   // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [0] truncated, [1] table_full
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLen  = 3'd1;
  localparam logic [2:0] StLenW = 3'd2;
  localparam logic [2:0] StCmp  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]      state;
  logic [LenW-1:0] word_length;
  logic            word_overflow;
  logic [CntW-1:0] seen_count;
  logic [EntW-1:0] ent;
  logic [LenW-1:0] pos;
  logic            cmp_wait;
  logic            full;
  logic            out_valid;
  result_t         out_reg;

  // Current word buffer.
  logic            wb_we;
  logic [PosW-1:0] wb_raddr;
  logic [7:0]      wb_rdata;
  // Seen bytes and lengths.
  logic              sb_we;
  logic [SeenAw-1:0] sb_waddr, sb_raddr;
  logic [7:0]        sb_rdata;
  logic              sl_we;
  logic [LenW-1:0]   sl_rdata;

  logic in_fire, is_end, out_free;
  assign s_axis_tready = (state == StIdle);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign is_end = s_axis_tuser || is_separator(s_axis_tdata);
  assign out_free = !out_valid || m_axis_tready;

  uwf_ram #(.Width(8), .Depth(MaxWordLen)) u_wb (
    .clk(clk), .we(wb_we), .waddr(word_length[PosW-1:0]), .wdata(s_axis_tdata),
    .raddr(wb_raddr), .rdata(wb_rdata));
  uwf_ram #(.Width(8), .Depth(TableDepth * MaxWordLen)) u_sb (
    .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(wb_rdata),
    .raddr(sb_raddr), .rdata(sb_rdata));
  uwf_ram #(.Width(LenW), .Depth(TableDepth)) u_sl (
    .clk(clk), .we(sl_we), .waddr(seen_count[EntW-1:0]), .wdata(word_length),
    .raddr(ent), .rdata(sl_rdata));

  assign wb_we = in_fire && !is_end && (word_length < LenW'(MaxWordLen));

  // Emit phase: pos counts issued reads; data trails it by one pipeline step.
  logic emit_step, emit_data;
  assign emit_step = (state == StEmit) && out_free;
  assign sb_raddr = {ent, pos[PosW-1:0]};
  assign sb_we = emit_step && cmp_wait && !full && (pos <= word_length);
  assign sb_waddr = {seen_count[EntW-1:0], PosW'(pos - LenW'(1))};
  assign sl_we = (state == StEmit) && (pos == '0) && !cmp_wait && !full;
  assign emit_data = cmp_wait;

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      word_length <= '0;
      word_overflow <= 1'b0;
      seen_count <= '0;
      out_valid <= 1'b0;
      ent <= '0;
      pos <= '0;
      cmp_wait <= 1'b0;
      full <= 1'b0;
    end else begin
      if (emit_step && emit_data) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (in_fire) begin
            if (!is_end) begin
              if (word_length < LenW'(MaxWordLen)) word_length <= word_length + 1'b1;
              else word_overflow <= 1'b1;
            end else if (word_length == '0) begin
              word_overflow <= 1'b0;
            end else begin
              ent <= '0;
              full <= (seen_count >= CntW'(TableDepth));
              state <= (seen_count == '0) ? StEmit : StLen;
              pos <= '0;
              cmp_wait <= 1'b0;
            end
          end
        end
        StLen: state <= StLenW;   // length read in flight
        StLenW: begin
          if (sl_rdata == word_length) begin
            pos <= LenW'(1);
            state <= StCmp;
          end else if (CntW'(ent) + 1'b1 >= seen_count) begin
            state <= StEmit;
            pos <= '0;
          end else begin
            ent <= ent + 1'b1;
            state <= StLen;
          end
        end
        StCmp: begin
          // Byte pos-1 of entry and word is on the read ports; addresses lead by one.
          if (sb_rdata != wb_rdata) begin
            pos <= '0;
            if (CntW'(ent) + 1'b1 >= seen_count) state <= StEmit;
            else begin
              ent <= ent + 1'b1;
              state <= StLen;
            end
          end else if (pos == word_length) begin
            word_length <= '0;
            word_overflow <= 1'b0;
            state <= StIdle;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        StEmit: begin
          if (!cmp_wait) begin
            cmp_wait <= 1'b1;
            pos <= LenW'(1);
          end else if (out_free) begin
            if (pos > word_length) begin
              if (!full) seen_count <= seen_count + 1'b1;
              word_length <= '0;
              word_overflow <= 1'b0;
              cmp_wait <= 1'b0;
              state <= StIdle;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // A held emit step reads byte pos-1 again so the buffer data stays in step.
  logic [PosW-1:0] rd_idx;
  always_comb begin
    rd_idx = pos[PosW-1:0];
    if (state == StEmit && cmp_wait && !out_free) rd_idx = PosW'(pos - LenW'(1));
  end
  assign wb_raddr = rd_idx;

  // Output register.
  always_ff @(posedge clk) begin
    if (emit_step && emit_data) begin
      out_reg.last <= (pos > word_length);
      out_reg.out_byte <= (pos > word_length) ? NewlineByte : wb_rdata;
      out_reg.truncated <= word_overflow;
      out_reg.table_full <= full;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_reg.out_byte;
  assign m_axis_tlast = out_reg.last;
  assign m_axis_tuser = {out_reg.table_full, out_reg.truncated};

  assert property (@(posedge clk) disable iff (rst)
    seen_count <= CntW'(TableDepth)) else $error("seen count overflow");
  assert property (@(posedge clk) disable iff (rst)
    word_length <= LenW'(MaxWordLen)) else $error("word length overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> out_valid) else $error("result dropped");

endmodule

// ----- verif/unique_word_filter_core_tb.sv -----
module unique_word_filter_core_tb;
  import uwf_pkg::*;

  localparam logic KindChar  = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Word splitter and seen-word table, tracked alongside the block.
  class word_set_scoreboard;
    logic [7:0] cur_word[MaxWordLen];
    int         cur_len;
    bit         cur_long;
    logic [7:0] kept_bytes[TableDepth][MaxWordLen];
    int         kept_len[TableDepth];
    int         kept_count;
    result_t    pending_out[$];
    int         errors;

    function new();
      cur_len = 0;
      cur_long = 0;
      kept_count = 0;
      errors = 0;
    endfunction

    static function bit sep_byte(logic [7:0] c);
      return (c >= 9 && c <= 13) || c == 32 || (c >= 33 && c <= 47) ||
             (c >= 58 && c <= 64) || (c >= 91 && c <= 96) || (c >= 123 && c <= 126);
    endfunction

    function bit known_word();
      bit same;
      for (int e = 0; e < kept_count; e++) begin
        if (kept_len[e] == cur_len) begin
          same = 1;
          for (int i = 0; i < cur_len; i++)
            if (kept_bytes[e][i] != cur_word[i]) same = 0;
          if (same) return 1;
        end
      end
      return 0;
    endfunction

    // Closes the pending word and queues the transfers it should produce.
    function void close_word();
      bit full;
      result_t r;
      if (cur_len != 0 && !known_word()) begin
        full = (kept_count >= TableDepth);
        if (!full) begin
          for (int i = 0; i < cur_len; i++) kept_bytes[kept_count][i] = cur_word[i];
          kept_len[kept_count] = cur_len;
          kept_count++;
        end
        for (int i = 0; i <= cur_len; i++) begin
          r.out_byte   = (i == cur_len) ? NewlineByte : cur_word[i];
          r.last       = (i == cur_len);
          r.truncated  = cur_long;
          r.table_full = full;
          pending_out.push_back(r);
        end
      end
      cur_len = 0;
      cur_long = 0;
    endfunction

    function void note_input(logic kind, logic [7:0] c);
      if (kind || sep_byte(c)) close_word();
      else if (cur_len < MaxWordLen) begin
        cur_word[cur_len] = c;
        cur_len++;
      end else cur_long = 1;
    endfunction

    function void check_result(logic [7:0] b, logic l, logic tr, logic tf);
      result_t want;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got byte %0d last %0b tuser %0b%0b",
                 $time, b, l, tf, tr);
        errors++;
        return;
      end
      want = pending_out.pop_front();
      if (want.out_byte != b) begin
        $display("%0t: out_byte expected %0d actual %0d", $time, want.out_byte, b);
        errors++;
      end
      if (want.last != l) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, l);
        errors++;
      end
      if (want.truncated != tr) begin
        $display("%0t: truncated expected %0b actual %0b", $time, want.truncated, tr);
        errors++;
      end
      if (want.table_full != tf) begin
        $display("%0t: table_full expected %0b actual %0b", $time, want.table_full, tf);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       s_axis_tvalid = 0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic       s_axis_tuser = 0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  word_set_scoreboard sb = new();
  bit quiet = 0;
  int sink_hold = 0;

  unique_word_filter_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]);
    end
  end

  // Output backpressure in short bursts.
  always @(negedge clk) begin
    if (quiet || rst) m_axis_tready <= !rst;
    else if (sink_hold > 0) begin
      m_axis_tready <= 0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(5) == 0) begin
      m_axis_tready <= 0;
      sink_hold <= int'($urandom_range(3));
    end else m_axis_tready <= 1;
  end

  task automatic send_item(input logic kind, input logic [7:0] c);
    @(negedge clk);
    if (!quiet && $urandom_range(5) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = kind;
    s_axis_tdata = c;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  function automatic logic [7:0] any_word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (word_set_scoreboard::sep_byte(c));
    return c;
  endfunction

  function automatic logic [7:0] any_sep_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (!word_set_scoreboard::sep_byte(c));
    return c;
  endfunction

  // A word of random content from a small or a full byte set, then a terminator.
  task automatic send_word(input int len, input bit narrow);
    for (int i = 0; i < len; i++)
      send_item(KindChar, narrow ? 8'(8'd97 + $urandom_range(1)) : any_word_byte());
    if ($urandom_range(7) == 0) send_item(KindFlush, 8'($urandom_range(255)));
    else send_item(KindChar, any_sep_byte());
  endtask

  task automatic random_words(input int count);
    int len;
    for (int w = 0; w < count; w++) begin
      case ($urandom_range(9))
        0: len = $urandom_range(40, 30);
        1: len = 0;
        default: len = $urandom_range(3, 1);
      endcase
      if ($urandom_range(9) == 0) send_item(KindChar, 8'($urandom_range(255)));
      else send_word(len, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    #20000000;
    $display("unique_word_filter_core: mismatch");
    $finish;
  end

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extreme bytes, a repeat, an empty word, flushes, a long word.
    send_item(KindChar, 8'd0);
    send_item(KindChar, 8'd255);
    send_item(KindChar, 8'd127);
    send_item(KindChar, 8'd32);
    send_item(KindChar, 8'd0);
    send_item(KindChar, 8'd255);
    send_item(KindChar, 8'd127);
    send_item(KindChar, 8'd9);
    send_item(KindChar, 8'd126);
    send_item(KindFlush, 8'd65);
    send_item(KindChar, 8'd65);
    send_item(KindFlush, 8'd255);
    send_item(KindFlush, 8'd0);
    for (int i = 0; i < 34; i++) send_item(KindChar, 8'd120);
    send_item(KindChar, 8'd47);
    for (int i = 0; i < 32; i++) send_item(KindChar, 8'd120);
    send_item(KindChar, 8'd13);

    // Random mix while the table still has room.
    random_words(6);

    // Every one-byte word, then distinct two-byte words until the table overflows.
    for (int i = 0; i < 256; i++) begin
      if (!word_set_scoreboard::sep_byte(8'(i))) begin
        send_item(KindChar, 8'(i));
        send_item(KindChar, any_sep_byte());
      end
    end
    for (int i = 0; i < 44; i++) begin
      send_item(KindChar, 8'd128);
      send_item(KindChar, 8'(128 + i));
      send_item(KindChar, any_sep_byte());
    end

    random_words(8);
    quiet = 1;
    random_words(4);
    send_item(KindFlush, 8'd0);
    @(negedge clk);
    s_axis_tvalid = 0;

    waited = 0;
    while (sb.pending_out.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_out.size() == 0)
      $display("unique_word_filter_core: match");
    else
      $display("unique_word_filter_core: mismatch");
    $finish;
  end
endmodule
